@@ rtl/eul_pkg.sv @@
`timescale 1ns / 1ps

package eul_pkg;

	// Signed Q.30 working format of the trig and product path
	typedef logic signed [31:0] q30_t;
	typedef logic signed [15:0] q14_t;

	// Angle scaled to Q.30 before range reduction: +/-4 rad needs 33 bits, held in 34
	localparam int ZQ_W = 34;
	typedef logic signed [ZQ_W-1:0] zq_t;

	localparam zq_t PI_Q30      = 34'sd3373259426;
	localparam zq_t HALF_PI_Q30 = 34'sd1686629713;

	// Gain-compensated start value, K for unlimited iterations
	localparam q30_t GAIN_Q30 = 32'sd652032874;

	localparam int TABLE_LEN   = 30;
	localparam int TABLE_IDX_W = 5;

	// atan(2^-i) in Q.30, rounded to nearest
	localparam q30_t ATAN_Q30 [TABLE_LEN] = '{
		32'sd843314857, 32'sd497837829, 32'sd263043836, 32'sd133525159,
		32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
		32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
		32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
		32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
		32'sd1024,      32'sd512,       32'sd256,       32'sd128,
		32'sd64,        32'sd32,        32'sd16,        32'sd8,
		32'sd4,         32'sd2
	};

	// Lane handshake status toward the top level
	typedef struct packed {
		logic ready;
		logic done;
	} lane_stat_t;

	// Raw lane result: x is cosine, y is sine, flip negates both
	typedef struct packed {
		logic flip;
		q30_t x;
		q30_t y;
	} trig_t;

endpackage

@@ rtl/eul_angle_if.sv @@
`timescale 1ns / 1ps

interface eul_angle_if #(
	parameter int ANGLE_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [ANGLE_BITS-1:0] yaw_angle;
	logic signed [ANGLE_BITS-1:0] pitch_angle;
	logic signed [ANGLE_BITS-1:0] roll_angle;

	modport source (
		output valid, yaw_angle, pitch_angle, roll_angle,
		input  ready
	);

	modport sink (
		input  valid, yaw_angle, pitch_angle, roll_angle,
		output ready
	);
endinterface

@@ rtl/eul_matrix_if.sv @@
`timescale 1ns / 1ps

interface eul_matrix_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] m00;
	logic signed [15:0] m01;
	logic signed [15:0] m02;
	logic signed [15:0] m10;
	logic signed [15:0] m11;
	logic signed [15:0] m12;
	logic signed [15:0] m20;
	logic signed [15:0] m21;
	logic signed [15:0] m22;

	modport source (
		output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		input  ready
	);

	modport sink (
		input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		output ready
	);
endinterface

@@ rtl/eul_cordic_lane.sv @@
`timescale 1ns / 1ps

module eul_cordic_lane import eul_pkg::*; #(
	parameter int ANGLE_BITS = 16,
	parameter int ITERATIONS = 14
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         take,
	input  logic signed [ANGLE_BITS-1:0] angle,
	output lane_stat_t                   stat,
	output trig_t                        trig
);

	localparam int N     = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;
	localparam int CNT_W = $clog2(N);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(N - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             flip_q;
	q30_t             x_q;
	q30_t             y_q;
	q30_t             z_q;

	zq_t  z_in;
	zq_t  z_red;
	logic flip_in;
	logic dir;
	q30_t dx;
	q30_t dy;
	q30_t atan_i;
	logic last_iter;

	// Scale Q3.(ANGLE_BITS-3) to Q.30, fold into [-pi/2, pi/2]
	always_comb begin
		z_in    = ZQ_W'(angle) <<< (33 - ANGLE_BITS);
		z_red   = z_in;
		flip_in = 1'b0;
		if (z_in > HALF_PI_Q30) begin
			z_red   = z_in - PI_Q30;
			flip_in = 1'b1;
		end else if (z_in < -HALF_PI_Q30) begin
			z_red   = z_in + PI_Q30;
			flip_in = 1'b1;
		end
	end

	assign dir       = ~z_q[31];
	assign dx        = y_q >>> cnt_q;
	assign dy        = x_q >>> cnt_q;
	assign atan_i    = ATAN_Q30[TABLE_IDX_W'(cnt_q)];
	assign last_iter = busy_q && (cnt_q == LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST)
					busy_q <= 1'b0;
				else
					cnt_q <= cnt_q + 1'b1;
			end
			if (last_iter)
				done_q <= 1'b1;
			else if (take)
				done_q <= 1'b0;
		end
	end

	// One micro-rotation per cycle, shift amount tracks the step count
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= GAIN_Q30;
			y_q    <= '0;
			z_q    <= z_red[31:0];
			flip_q <= flip_in;
		end else if (busy_q) begin
			if (dir) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_i;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_i;
			end
		end
	end

	assign stat.ready = !busy_q && (!done_q || take);
	assign stat.done  = done_q;
	assign trig.flip  = flip_q;
	assign trig.x     = x_q;
	assign trig.y     = y_q;

`ifndef NO_ASSERTIONS
	a_last_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		last_iter |=> (done_q && !busy_q))
		else $error("lane did not finish after its last step");
`endif

endmodule

@@ rtl/eul_dcm_merge.sv @@
`timescale 1ns / 1ps

module eul_dcm_merge import eul_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            lanes_done,
	input  trig_t           yaw_trig,
	input  trig_t           pitch_trig,
	input  trig_t           roll_trig,
	output logic            take,
	eul_matrix_if.source    matrix
);

	// Q.30 product, rounded half up
	function automatic q30_t mul_q30(input q30_t a, input q30_t b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b) + 64'sd536870912;
		return p[61:30];
	endfunction

	// Round to Q1.14 half up, clamp to +/-1
	function automatic q14_t to_q14(input logic signed [32:0] v);
		logic signed [33:0] t;
		logic signed [17:0] r;
		q14_t               res;
		t = 34'(v) + 34'sd32768;
		r = t[33:16];
		if (r > 18'sd16384)
			res = 16'sd16384;
		else if (r < -18'sd16384)
			res = -16'sd16384;
		else
			res = r[15:0];
		return res;
	endfunction

	logic adv;
	logic v_s0, v_s1, v_s2, v_s3, v_s4;

	q30_t sy_s0, cy_s0, sp_s0, cp_s0, sr_s0, cr_s0;

	q30_t srsp_s1, crsp_s1, cpcy_s1, crsy_s1, srsy_s1;
	q30_t cpsy_s1, crcy_s1, srcy_s1, srcp_s1, crcp_s1;
	q30_t sy_s1, cy_s1, sp_s1;

	q30_t srspcy_s2, crspcy_s2, srspsy_s2, crspsy_s2;
	q30_t cpcy_s2, crsy_s2, srsy_s2, cpsy_s2, crcy_s2, srcy_s2, srcp_s2, crcp_s2;
	q30_t sp_s2;

	logic signed [32:0] e_s3 [9];
	q14_t               m_s4 [9];

	// Whole pipe moves together; hold everything while the result waits
	assign adv  = !v_s4 || matrix.ready;
	assign take = lanes_done && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s0 <= take;
			v_s1 <= v_s0;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// capture lanes, undo the half-turn fold
			sy_s0 <= yaw_trig.flip   ? -yaw_trig.y   : yaw_trig.y;
			cy_s0 <= yaw_trig.flip   ? -yaw_trig.x   : yaw_trig.x;
			sp_s0 <= pitch_trig.flip ? -pitch_trig.y : pitch_trig.y;
			cp_s0 <= pitch_trig.flip ? -pitch_trig.x : pitch_trig.x;
			sr_s0 <= roll_trig.flip  ? -roll_trig.y  : roll_trig.y;
			cr_s0 <= roll_trig.flip  ? -roll_trig.x  : roll_trig.x;

			// pairwise products
			srsp_s1 <= mul_q30(sr_s0, sp_s0);
			crsp_s1 <= mul_q30(cr_s0, sp_s0);
			cpcy_s1 <= mul_q30(cp_s0, cy_s0);
			crsy_s1 <= mul_q30(cr_s0, sy_s0);
			srsy_s1 <= mul_q30(sr_s0, sy_s0);
			cpsy_s1 <= mul_q30(cp_s0, sy_s0);
			crcy_s1 <= mul_q30(cr_s0, cy_s0);
			srcy_s1 <= mul_q30(sr_s0, cy_s0);
			srcp_s1 <= mul_q30(sr_s0, cp_s0);
			crcp_s1 <= mul_q30(cr_s0, cp_s0);
			sy_s1   <= sy_s0;
			cy_s1   <= cy_s0;
			sp_s1   <= sp_s0;

			// triple products, left to right
			srspcy_s2 <= mul_q30(srsp_s1, cy_s1);
			crspcy_s2 <= mul_q30(crsp_s1, cy_s1);
			srspsy_s2 <= mul_q30(srsp_s1, sy_s1);
			crspsy_s2 <= mul_q30(crsp_s1, sy_s1);
			cpcy_s2   <= cpcy_s1;
			crsy_s2   <= crsy_s1;
			srsy_s2   <= srsy_s1;
			cpsy_s2   <= cpsy_s1;
			crcy_s2   <= crcy_s1;
			srcy_s2   <= srcy_s1;
			srcp_s2   <= srcp_s1;
			crcp_s2   <= crcp_s1;
			sp_s2     <= sp_s1;

			// exact sums
			e_s3[0] <= 33'(cpcy_s2);
			e_s3[1] <= 33'(srspcy_s2) - 33'(crsy_s2);
			e_s3[2] <= 33'(srsy_s2) + 33'(crspcy_s2);
			e_s3[3] <= 33'(cpsy_s2);
			e_s3[4] <= 33'(crcy_s2) + 33'(srspsy_s2);
			e_s3[5] <= 33'(crspsy_s2) - 33'(srcy_s2);
			e_s3[6] <= -33'(sp_s2);
			e_s3[7] <= 33'(srcp_s2);
			e_s3[8] <= 33'(crcp_s2);

			for (int k = 0; k < 9; k++)
				m_s4[k] <= to_q14(e_s3[k]);
		end
	end

	assign matrix.valid = v_s4;
	assign matrix.m00   = m_s4[0];
	assign matrix.m01   = m_s4[1];
	assign matrix.m02   = m_s4[2];
	assign matrix.m10   = m_s4[3];
	assign matrix.m11   = m_s4[4];
	assign matrix.m12   = m_s4[5];
	assign matrix.m20   = m_s4[6];
	assign matrix.m21   = m_s4[7];
	assign matrix.m22   = m_s4[8];

endmodule

@@ rtl/euler_to_rotation_matrix_top.sv @@
`timescale 1ns / 1ps

// A new angle set is accepted only after the lanes finish iterating on the
// previous one in the iterative CORDIC loop of each lane; the product
// pipeline overlaps with the lanes working on the next set.
// Reset: arst_n asynchronously clears lane and pipeline valid state; no
// stored data survives an item, so no clearing pass is needed.
module euler_to_rotation_matrix_top import eul_pkg::*; #(
	parameter int ANGLE_BITS      = 16,
	parameter int TRIG_ITERATIONS = 14
) (
	input  logic         clk,
	input  logic         arst_n,
	eul_angle_if.sink    angles,
	eul_matrix_if.source matrix
);

	// Three CORDIC lanes (yaw, pitch, roll) run in lockstep. They start on
	// the same transaction and finish in the same cycle, so any one status
	// stands for all; the AND keeps the handshake honest regardless.
	lane_stat_t stat [3];
	trig_t      trig [3];

	logic start;
	logic take;
	logic lanes_done;

	// Accept a new angle set once lanes are idle and their previous result
	// is either gone or being handed to the product pipe this cycle.
	assign angles.ready = stat[0].ready & stat[1].ready & stat[2].ready;
	assign start        = angles.valid && angles.ready;
	assign lanes_done   = stat[0].done & stat[1].done & stat[2].done;

	eul_cordic_lane #(
		.ANGLE_BITS (ANGLE_BITS),
		.ITERATIONS (TRIG_ITERATIONS)
	) u_lane_yaw (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.take   (take),
		.angle  (angles.yaw_angle),
		.stat   (stat[0]),
		.trig   (trig[0])
	);

	eul_cordic_lane #(
		.ANGLE_BITS (ANGLE_BITS),
		.ITERATIONS (TRIG_ITERATIONS)
	) u_lane_pitch (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.take   (take),
		.angle  (angles.pitch_angle),
		.stat   (stat[1]),
		.trig   (trig[1])
	);

	eul_cordic_lane #(
		.ANGLE_BITS (ANGLE_BITS),
		.ITERATIONS (TRIG_ITERATIONS)
	) u_lane_roll (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.take   (take),
		.angle  (angles.roll_angle),
		.stat   (stat[2]),
		.trig   (trig[2])
	);

	// Merge: fold correction, products, sums, Q1.14 rounding and clamp.
	// Its last stage is the output register, so the lanes keep working on
	// the next transaction while a finished matrix waits downstream.
	eul_dcm_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.lanes_done (lanes_done),
		.yaw_trig   (trig[0]),
		.pitch_trig (trig[1]),
		.roll_trig  (trig[2]),
		.take       (take),
		.matrix     (matrix)
	);

`ifndef NO_ASSERTIONS
	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(stat[0] == stat[1]) && (stat[1] == stat[2]))
		else $error("CORDIC lanes out of step");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !angles.ready)
		else $error("input ready while lanes iterate");

	a_take_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (stat[0].done && stat[1].done && stat[2].done))
		else $error("product pipe took an unfinished lane result");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		matrix.valid |-> (matrix.m01 <= 16'sd16384 && matrix.m01 >= -16'sd16384
			&& matrix.m11 <= 16'sd16384 && matrix.m11 >= -16'sd16384))
		else $error("matrix element beyond unity");
`endif

endmodule

@@ dv/tb_euler_to_rotation_matrix_top.sv @@
`timescale 1ns / 1ps

module tb_euler_to_rotation_matrix_top import eul_pkg::*;;

	localparam int ANGLE_BITS      = 16;
	localparam int TRIG_ITERATIONS = 14;
	localparam int CORDIC_STEPS    =
		(TRIG_ITERATIONS > TABLE_LEN) ? TABLE_LEN : TRIG_ITERATIONS;

	// Angle transaction to matrix valid, with no receiver stall
	localparam int LATENCY      = TRIG_ITERATIONS + 5;
	localparam int DRAIN_CYCLES = 4 * LATENCY;
	localparam int RANDOM_SETS  = 1000;
	// Slowest run: ~1020 sets, each with idle time from the sender, one trig
	// pass and a receiver hold; allow 4x.
	localparam int CYCLE_LIMIT  = 500000;
	localparam int REPORT_LIMIT = 10;

	typedef logic signed [ANGLE_BITS-1:0] angle_t;
	// Matrix elements row by row: index 0 is m00, index 8 is m22
	typedef logic [8:0][15:0] dcm_t;

	typedef struct packed {
		angle_t yaw;
		angle_t pitch;
		angle_t roll;
		dcm_t   m;
	} dcm_entry_t;

	// Receiver back-pressure modes
	typedef enum logic [1:0] {
		RX_STREAM,
		RX_COIN,
		RX_ALTERNATE,
		RX_HOLD
	} rx_mode_e;

	// Directed angle sets: yaw, pitch, roll in Q3.13 radians.
	// Covers zero angles (cosine lands on one and must saturate), both range
	// extremes, values on either side of +/- pi/2 where range reduction kicks
	// in, values near +/- pi, gimbal lock in pitch, and alternating bit patterns.
	localparam angle_t EDGE_ANGLES [20][3] = '{
		'{0, 0, 0},
		'{32767, 32767, 32767},
		'{-32768, -32768, -32768},
		'{12867, 12868, -12867},
		'{-12868, 12867, 12868},
		'{25736, -25736, 25735},
		'{0, 12868, 0},
		'{0, -12868, 0},
		'{1, -1, 1},
		'{-1, 1, -1},
		'{6434, 6434, 6434},
		'{-6434, 6434, -6434},
		'{32767, 0, -32768},
		'{-32768, 32767, 0},
		'{8192, -8192, 16384},
		'{-16384, 16384, -24576},
		'{0, 0, 12868},
		'{12868, 0, 0},
		'{21845, -21846, 10922},
		'{-21846, 21845, -10923}
	};

	// Scoreboard: predicts the direction cosine matrix for each accepted angle
	// set and checks matrix transactions against it in order.
	class dcm_scoreboard;
		dcm_entry_t pending_dcm[$];
		int         failures;
		string      elem_name[9] = '{"m00", "m01", "m02", "m10", "m11", "m12",
			"m20", "m21", "m22"};

		function new();
			failures = 0;
		endfunction

		function int pending();
			return pending_dcm.size();
		endfunction

		function void flag(string msg);
			failures++;
			if (failures <= REPORT_LIMIT)
				$display("[%0t] mismatch: %s", $time, msg);
		endfunction

		// Q.30 times Q.30, rounded back to Q.30 with ties toward plus infinity
		function longint q30_mul(longint a, longint b);
			return (a * b + (64'sd1 <<< 29)) >>> 30;
		endfunction

		function q14_t q30_to_q14(longint v);
			longint r;
			r = (v + 64'sd32768) >>> 16;
			if (r > 16384)
				r = 16384;
			if (r < -16384)
				r = -16384;
			return q14_t'(r);
		endfunction

		// Rotation-mode CORDIC after folding the angle into [-pi/2, pi/2]
		function void sin_cos_q30(angle_t a, output longint s, output longint c);
			longint z, x, y, dx, dy;
			bit     flip;
			int     i;
			z    = longint'(a) * (64'sd1 <<< (33 - ANGLE_BITS));
			x    = longint'(GAIN_Q30);
			y    = 0;
			flip = 1'b0;
			if (z > longint'(HALF_PI_Q30)) begin
				z    = z - longint'(PI_Q30);
				flip = 1'b1;
			end else if (z < -longint'(HALF_PI_Q30)) begin
				z    = z + longint'(PI_Q30);
				flip = 1'b1;
			end
			for (i = 0; i < CORDIC_STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx;
					y = y + dy;
					z = z - longint'(ATAN_Q30[i]);
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + longint'(ATAN_Q30[i]);
				end
			end
			s = flip ? -y : y;
			c = flip ? -x : x;
		endfunction

		function dcm_t predict_dcm(angle_t yaw, angle_t pitch, angle_t roll);
			longint sy, cy, sp, cp, sr, cr, srsp, crsp;
			dcm_t   m;
			sin_cos_q30(yaw, sy, cy);
			sin_cos_q30(pitch, sp, cp);
			sin_cos_q30(roll, sr, cr);
			srsp = q30_mul(sr, sp);
			crsp = q30_mul(cr, sp);
			m[0] = q30_to_q14(q30_mul(cp, cy));
			m[1] = q30_to_q14(q30_mul(srsp, cy) - q30_mul(cr, sy));
			m[2] = q30_to_q14(q30_mul(sr, sy) + q30_mul(crsp, cy));
			m[3] = q30_to_q14(q30_mul(cp, sy));
			m[4] = q30_to_q14(q30_mul(cr, cy) + q30_mul(srsp, sy));
			m[5] = q30_to_q14(q30_mul(crsp, sy) - q30_mul(sr, cy));
			m[6] = q30_to_q14(-sp);
			m[7] = q30_to_q14(q30_mul(sr, cp));
			m[8] = q30_to_q14(q30_mul(cr, cp));
			return m;
		endfunction

		function void note_angles(angle_t yaw, angle_t pitch, angle_t roll);
			dcm_entry_t e;
			e.yaw   = yaw;
			e.pitch = pitch;
			e.roll  = roll;
			e.m     = predict_dcm(yaw, pitch, roll);
			pending_dcm.push_back(e);
		endfunction

		function void check_matrix(dcm_t got);
			dcm_entry_t e;
			int         k;
			if (pending_dcm.size() == 0) begin
				flag("matrix transaction with no angle set outstanding");
				return;
			end
			e = pending_dcm.pop_front();
			for (k = 0; k < 9; k++) begin
				if (got[k] !== e.m[k])
					flag($sformatf("%s expected %0d got %0d (yaw %0d pitch %0d roll %0d)",
						elem_name[k], $signed(e.m[k]), $signed(got[k]),
						e.yaw, e.pitch, e.roll));
			end
		endfunction

		function void check_drained();
			if (pending_dcm.size() != 0)
				flag($sformatf("%0d matrix transactions never arrived", pending_dcm.size()));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	eul_angle_if #(.ANGLE_BITS(ANGLE_BITS)) angles_if ();
	eul_matrix_if                           matrix_if ();

	euler_to_rotation_matrix_top #(
		.ANGLE_BITS      (ANGLE_BITS),
		.TRIG_ITERATIONS (TRIG_ITERATIONS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.angles (angles_if.sink),
		.matrix (matrix_if.source)
	);

	dcm_scoreboard sb;
	int            burst_left;
	int            cycle_count;

	always #6 clk = ~clk;

	// Return an angle: mostly uniform over the full field, with a share
	// clustered at the range-reduction boundaries, near pi, near zero and
	// at the field extremes.
	function automatic angle_t rand_angle();
		int pick;
		int v;
		pick = $urandom_range(0, 9);
		case (pick)
			6: begin
				v = 12860 + int'($urandom_range(0, 16));
				if ($urandom_range(0, 1))
					v = -v;
			end
			7: begin
				v = 25728 + int'($urandom_range(0, 16));
				if ($urandom_range(0, 1))
					v = -v;
			end
			8: v = int'($urandom_range(0, 128)) - 64;
			9: begin
				case ($urandom_range(0, 3))
					0: v = 32767;
					1: v = -32768;
					2: v = 0;
					default: v = -1;
				endcase
			end
			default: v = int'($urandom);
		endcase
		return angle_t'(v);
	endfunction

	// Present one angle set and hold it until the block takes it. Between
	// bursts of random length, drop valid for a random gap so idle cycles
	// land on every phase of the CORDIC loop; some bursts follow back to back.
	task automatic send_angles(angle_t yaw, angle_t pitch, angle_t roll);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				angles_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		angles_if.valid       <= 1'b1;
		angles_if.yaw_angle   <= yaw;
		angles_if.pitch_angle <= pitch;
		angles_if.roll_angle  <= roll;
		do @(posedge clk); while (!angles_if.ready);
	endtask

	// Receiver back-pressure: pick a mode for a random run of cycles. Stream
	// keeps ready high, coin flips it each cycle, alternate toggles it, and
	// hold stalls outright for the whole run. Hold ready low during reset.
	always @(posedge clk) begin : rx_pattern
		static rx_mode_e mode   = RX_STREAM;
		static int       run_left = 0;
		if (!arst_n) begin
			matrix_if.ready <= 1'b0;
		end else begin
			if (run_left == 0) begin
				mode     = rx_mode_e'($urandom_range(0, 3));
				run_left = (mode == RX_HOLD) ? $urandom_range(1, 40) : $urandom_range(8, 120);
			end else begin
				run_left--;
			end
			case (mode)
				RX_STREAM:    matrix_if.ready <= 1'b1;
				RX_COIN:      matrix_if.ready <= $urandom_range(0, 1);
				RX_ALTERNATE: matrix_if.ready <= ~matrix_if.ready;
				default:      matrix_if.ready <= 1'b0;
			endcase
		end
	end

	// Both monitors sample pre-edge values, so they see exactly the
	// transactions the block sees at this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (angles_if.valid && angles_if.ready)
				sb.note_angles(angles_if.yaw_angle, angles_if.pitch_angle,
					angles_if.roll_angle);
			if (matrix_if.valid && matrix_if.ready)
				sb.check_matrix({matrix_if.m22, matrix_if.m21, matrix_if.m20,
					matrix_if.m12, matrix_if.m11, matrix_if.m10,
					matrix_if.m02, matrix_if.m01, matrix_if.m00});
		end
	end

	// Watchdog: advance the cycle counter and end the run on a hang.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int i;
		sb         = new();
		burst_left = 0;

		// Hold reset and drive the angle inputs to a known value from time zero
		arst_n                <= 1'b0;
		angles_if.valid       <= 1'b0;
		angles_if.yaw_angle   <= '0;
		angles_if.pitch_angle <= '0;
		angles_if.roll_angle  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sets first
		for (i = 0; i < 20; i++)
			send_angles(EDGE_ANGLES[i][0], EDGE_ANGLES[i][1], EDGE_ANGLES[i][2]);

		// Then random sets; every set produces one matrix
		for (i = 0; i < RANDOM_SETS; i++)
			send_angles(rand_angle(), rand_angle(), rand_angle());
		angles_if.valid <= 1'b0;

		// Drain: wait for every outstanding matrix, then let the pipeline
		// settle so a stray extra transaction would still be caught.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.check_drained();

		if (sb.failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/eul_pkg.sv
rtl/eul_angle_if.sv
rtl/eul_matrix_if.sv
rtl/eul_cordic_lane.sv
rtl/eul_dcm_merge.sv
rtl/euler_to_rotation_matrix_top.sv
dv/tb_euler_to_rotation_matrix_top.sv
